// ===== rtl/multi_key_debounce_edge_latch_macros.svh =====
// Assertion macros shared by the key debouncer RTL.
`ifndef MULTI_KEY_DEBOUNCE_EDGE_LATCH_MACROS_SVH
`define MULTI_KEY_DEBOUNCE_EDGE_LATCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mkd_pkg.sv =====
// Package: constants, word types and control structs of the key debouncer.
`timescale 1ns / 1ps
`default_nettype none
package mkd_pkg;

  localparam int NUM_KEYS      = 5;
  localparam int ADC_BITS      = 12;
  localparam int GPIO_BITS     = 4;
  localparam int CNT_BITS      = 5;
  localparam int CONF_BITS     = 4;
  localparam int IDX_BITS      = 3;
  localparam int CMD_BITS      = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_TICK       = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_RD_PRESS   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RD_RELEASE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_THRESH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_THRESH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM     = 2'd2;

  // Register reset values
  localparam logic [ADC_BITS-1:0]  LOW_THRESH_RST  = 12'h300;
  localparam logic [ADC_BITS-1:0]  HIGH_THRESH_RST = 12'hF00;
  localparam logic [CONF_BITS-1:0] CONFIRM_RST     = 4'd2;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [IDX_BITS-1:0]  key_index;
    logic [ADC_BITS-1:0]  adc_sample;
    logic [GPIO_BITS-1:0] gpio_levels;
  } in_word_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] stable_levels;
    logic                edge_seen;
    logic                key_level;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] wdata;
  } cfg_word_t;

  // Current register values
  typedef struct packed {
    logic [ADC_BITS-1:0]  low_thresh;
    logic [ADC_BITS-1:0]  high_thresh;
    logic [CONF_BITS-1:0] confirm;
  } cfg_regs_t;

  // Per-key control, already qualified by the pipeline advance
  typedef struct packed {
    logic tick;
    logic raw_pressed;
    logic clr_press;
    logic clr_release;
  } key_ctrl_t;

  // Per-key status
  typedef struct packed {
    logic press_flag;
    logic release_flag;
    logic level_nxt;
  } key_stat_t;

endpackage
`default_nettype wire

// ===== rtl/mkd_chan_if.sv =====
// Valid/ready channel interface carrying one word of a given type.
`timescale 1ns / 1ps
`default_nettype none
interface mkd_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mkd_cfg_regs.sv =====
// Configuration register file: thresholds and confirm count.
`timescale 1ns / 1ps
`default_nettype none
module mkd_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  mkd_chan_if.sink          cfg_ch,
  output mkd_pkg::cfg_regs_t regs
);

  mkd_pkg::cfg_regs_t regs_r;
  mkd_pkg::cfg_regs_t regs_nxt;

  assign cfg_ch.ready = 1'b1;

  // Decode the register write
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        mkd_pkg::REG_LOW_THRESH:
          regs_nxt.low_thresh = cfg_ch.data.wdata[mkd_pkg::ADC_BITS-1:0];
        mkd_pkg::REG_HIGH_THRESH:
          regs_nxt.high_thresh = cfg_ch.data.wdata[mkd_pkg::ADC_BITS-1:0];
        mkd_pkg::REG_CONFIRM:
          regs_nxt.confirm = cfg_ch.data.wdata[mkd_pkg::CONF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.low_thresh  <= mkd_pkg::LOW_THRESH_RST;
      regs_r.high_thresh <= mkd_pkg::HIGH_THRESH_RST;
      regs_r.confirm     <= mkd_pkg::CONFIRM_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule
`default_nettype wire

// ===== rtl/mkd_key_cell.sv =====
// One key: press/release counters, confirmed shadow, reported level, edge flags.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_key_debounce_edge_latch_macros.svh"
module mkd_key_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [mkd_pkg::CONF_BITS-1:0] confirm,
  input  wire mkd_pkg::key_ctrl_t            ctrl,
  output mkd_pkg::key_stat_t                 stat
);

  logic [mkd_pkg::CNT_BITS-1:0] press_cnt_r, press_cnt_nxt;
  logic [mkd_pkg::CNT_BITS-1:0] release_cnt_r, release_cnt_nxt;
  logic                         shadow_r, shadow_nxt;
  logic                         reported_r, reported_nxt;
  logic                         press_flag_r, press_flag_nxt;
  logic                         release_flag_r, release_flag_nxt;
  logic [mkd_pkg::CNT_BITS-1:0] cnt_inc;
  logic                         confirmed;

  // Count the steady level; the other counter restarts
  assign cnt_inc   = ctrl.raw_pressed ? press_cnt_r + 1'b1 : release_cnt_r + 1'b1;
  assign confirmed = cnt_inc > {1'b0, confirm};

  always_comb begin
    press_cnt_nxt    = press_cnt_r;
    release_cnt_nxt  = release_cnt_r;
    shadow_nxt       = shadow_r;
    reported_nxt     = reported_r;
    press_flag_nxt   = press_flag_r;
    release_flag_nxt = release_flag_r;
    if (ctrl.tick) begin
      if (ctrl.raw_pressed) begin
        press_cnt_nxt   = confirmed ? '0 : cnt_inc;
        release_cnt_nxt = '0;
      end else begin
        release_cnt_nxt = confirmed ? '0 : cnt_inc;
        press_cnt_nxt   = '0;
      end
      // New level: update shadow and latch edge; repeat: report it
      if (confirmed) begin
        if (shadow_r != ctrl.raw_pressed) begin
          shadow_nxt = ctrl.raw_pressed;
          if (ctrl.raw_pressed) begin
            press_flag_nxt = 1'b1;
          end else begin
            release_flag_nxt = 1'b1;
          end
        end else begin
          reported_nxt = shadow_r;
        end
      end
    end
    if (ctrl.clr_press) begin
      press_flag_nxt = 1'b0;
    end
    if (ctrl.clr_release) begin
      release_flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_cnt_r    <= '0;
      release_cnt_r  <= '0;
      shadow_r       <= 1'b0;
      reported_r     <= 1'b0;
      press_flag_r   <= 1'b0;
      release_flag_r <= 1'b0;
    end else begin
      press_cnt_r    <= press_cnt_nxt;
      release_cnt_r  <= release_cnt_nxt;
      shadow_r       <= shadow_nxt;
      reported_r     <= reported_nxt;
      press_flag_r   <= press_flag_nxt;
      release_flag_r <= release_flag_nxt;
    end
  end

  assign stat.press_flag   = press_flag_r;
  assign stat.release_flag = release_flag_r;
  assign stat.level_nxt    = reported_nxt;

  // Only one counter can be running at a time
  `MKD_ASSERT_NOW(a_one_counter, clk, rst_n, 1'b1, (press_cnt_r == '0) || (release_cnt_r == '0), "both key counters running")
  // Reported level moves only on a tick
  `MKD_ASSERT_NEXT(a_level_on_tick, clk, rst_n, !ctrl.tick, $stable(reported_r), "reported level changed without tick")
  // Shadow moves only on a tick
  `MKD_ASSERT_NEXT(a_shadow_on_tick, clk, rst_n, !ctrl.tick, $stable(shadow_r), "shadow changed without tick")

endmodule
`default_nettype wire

// ===== rtl/multi_key_debounce_edge_latch.sv =====
// Top level: input register, key cells and result register of the key debouncer.
//
// Usage:
//   in_ch carries one word per command: tick (sample the ADC key and GPIO keys),
//   read-and-clear the press edge flag, or read-and-clear the release edge flag
//   of key_index. Every accepted word yields exactly one result word on out_ch:
//   the reported levels of all keys, the addressed edge flag before clearing
//   (0 on tick) and the reported level of the addressed key.
//   cfg_ch writes the low/high ADC thresholds and the confirm count; it is always
//   ready and should be written only while no word is in flight.
// Timing:
//   A word accepted into the input register is processed by the key cells and
//   lands in the result register when it advances, that is once the result
//   register is empty or its word is being taken.
//   Throughput is one word per cycle while out_ch takes results; the key
//   cells update in the same cycle the word moves to the result register.
// Reset:
//   rst_n (synchronous) clears counters, levels, flags and both registers'
//   valid bits and loads threshold 0x300/0xF00 and confirm count 2.
// Back-pressure:
//   While out_ch is stalled the result holds, the input register holds one more
//   word, and in_ch.ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_key_debounce_edge_latch_macros.svh"
module multi_key_debounce_edge_latch (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mkd_chan_if.sink   in_ch,
  mkd_chan_if.source out_ch,
  mkd_chan_if.sink   cfg_ch
);

  localparam int NK = mkd_pkg::NUM_KEYS;

  mkd_pkg::cfg_regs_t regs;
  logic               in_valid_r, in_valid_nxt;
  mkd_pkg::in_word_t  in_word_r;
  logic               out_valid_r, out_valid_nxt;
  mkd_pkg::out_word_t out_word_r, out_word_nxt;
  logic               advance;
  logic               is_tick, is_rd_press, is_rd_release, idx_ok;
  logic               adc_pressed;
  logic [NK-1:0]      press_flags, release_flags, levels_nxt;

  mkd_pkg::key_ctrl_t key_ctrl [NK];
  mkd_pkg::key_stat_t key_stat [NK];

  mkd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  // Pipeline control
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ch.ready) begin
      in_valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_word_r <= in_ch.data;
    end
  end

  // Command decode
  assign is_tick       = in_word_r.command == mkd_pkg::CMD_TICK;
  assign is_rd_press   = in_word_r.command == mkd_pkg::CMD_RD_PRESS;
  assign is_rd_release = in_word_r.command == mkd_pkg::CMD_RD_RELEASE;
  assign idx_ok        = in_word_r.key_index < mkd_pkg::IDX_BITS'(NK);

  // Analog key: low test, then high test; any sample up to high_thresh reads pressed
  assign adc_pressed = (in_word_r.adc_sample < regs.low_thresh) ||
                       !(in_word_r.adc_sample > regs.high_thresh);

  // Key cells
  for (genvar k = 0; k < NK; k++) begin : g_key
    logic raw;
    logic hit;

    if (k == 0) begin : g_adc
      assign raw = adc_pressed;
    end else if (k - 1 < mkd_pkg::GPIO_BITS) begin : g_gpio
      assign raw = !in_word_r.gpio_levels[k-1];
    end else begin : g_none
      assign raw = 1'b1;
    end

    assign hit = in_word_r.key_index == mkd_pkg::IDX_BITS'(k);

    assign key_ctrl[k].tick        = advance && is_tick;
    assign key_ctrl[k].raw_pressed = raw;
    assign key_ctrl[k].clr_press   = advance && is_rd_press && hit;
    assign key_ctrl[k].clr_release = advance && is_rd_release && hit;

    mkd_key_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .confirm (regs.confirm),
      .ctrl    (key_ctrl[k]),
      .stat    (key_stat[k])
    );

    assign press_flags[k]   = key_stat[k].press_flag;
    assign release_flags[k] = key_stat[k].release_flag;
    assign levels_nxt[k]    = key_stat[k].level_nxt;
  end

  // Result word
  always_comb begin
    out_word_nxt.stable_levels = levels_nxt;
    out_word_nxt.edge_seen     = 1'b0;
    out_word_nxt.key_level     = 1'b0;
    if (idx_ok) begin
      out_word_nxt.key_level = levels_nxt[in_word_r.key_index];
      if (is_rd_press) begin
        out_word_nxt.edge_seen = press_flags[in_word_r.key_index];
      end else if (is_rd_release) begin
        out_word_nxt.edge_seen = release_flags[in_word_r.key_index];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // Input is refused only while a word waits in the input register
  `MKD_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !in_ch.ready, in_valid_r, "input refused with empty stage")
  // A word moving on always shows up as a result next cycle
  `MKD_ASSERT_NEXT(a_advance_result, clk, rst_n, advance, out_valid_r, "advanced word lost")
  // A staged word that cannot move stays staged
  `MKD_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_valid_r && !advance, in_valid_r, "stalled word dropped")

endmodule
`default_nettype wire
